@@ design/murmur2_byte_stream_hash_core_macros.svh @@
// Assertion macros shared by the hash core's checker.
// Depends on nothing; the user scope must provide clk and rst_n.
`ifndef MURMUR2_BYTE_STREAM_HASH_CORE_MACROS_SVH
`define MURMUR2_BYTE_STREAM_HASH_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define M2_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define M2_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/m2bsh_pkg.sv @@
// Constants shared by the MurmurHash2 byte-stream core and its multiplier.
// No dependencies.
`timescale 1ns / 1ps

package m2bsh_pkg;

  typedef logic [31:0] word_t;

  localparam word_t       MIX_MUL         = 32'h5bd1e995;
  localparam word_t       SEED_RESET      = 32'h7870AAFF;
  localparam int unsigned WORD_SHIFT      = 24;
  localparam int unsigned END_SHIFT_A     = 13;
  localparam int unsigned END_SHIFT_B     = 15;
  localparam int unsigned LENGTH_BITS_DEF = 16;

endpackage

@@ design/murmur2_byte_stream_hash_core.sv @@
// Channel | Dir | Handshake          | Payload
// in      | in  | in_valid/in_stall  | data_byte, start_of_message, message_length, last_byte
// out     | out | out_valid/out_stall| hash_value
// cfg     | in  | cfg_valid/cfg_ready| hash_seed
//
// A byte that does not complete a word or the message is merged into the word. A byte
// that completes a word takes three passes through the one shared multiplier (K1, K2,
// H1), then H2 folds k into h. A last byte that leaves a partial word takes the tail
// steps T1 and T2 in place of the word's steps; the last byte then adds the end mix
// (F1, F2) and EMIT, which hands off the result. An empty message goes straight to EMIT.
// rst_n is synchronous; the seed returns to 0x7870AAFF. A stalled result holds in
// the output register while the next item is taken; a later result waits for it.
// Depends on m2bsh_pkg and m2bsh_mul.
`timescale 1ns / 1ps

module murmur2_byte_stream_hash_core #(
  parameter int unsigned LENGTH_BITS = m2bsh_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_message,
  input  logic [15:0] in_message_length,
  input  logic        in_last_byte,      // end is decided by the length count
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value,
  // seed register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_hash_seed
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_K1,   // k * M
    S_K2,   // (k ^ k>>24) * M
    S_H1,   // h * M, latch k
    S_H2,   // h = h*M ^ k
    S_T1,   // (h ^ tail) * M
    S_T2,   // latch tail product
    S_F1,   // (h ^ h>>13) * M
    S_F2,   // h ^ h>>15
    S_EMIT  // wait for the output register
  } state_t;

  typedef logic [LENGTH_BITS-1:0] len_t;

  state_t           state_r, state_nxt;
  m2bsh_pkg::word_t seed_r, seed_nxt;
  m2bsh_pkg::word_t h_r, h_nxt;
  m2bsh_pkg::word_t w_r, w_nxt;
  m2bsh_pkg::word_t k_r, k_nxt;
  logic [1:0]       lane_r, lane_nxt;
  len_t             rem_r, rem_nxt;
  logic             fin_r, fin_nxt;
  logic             out_valid_r, out_valid_nxt;
  m2bsh_pkg::word_t out_hash_r, out_hash_nxt;

  m2bsh_pkg::word_t mul_a;
  m2bsh_pkg::word_t mul_p;

  logic             in_acc;
  logic             out_acc;
  logic [31:0]      len_ext;
  len_t             len_m;
  m2bsh_pkg::word_t w_base, w_new, k_mix;
  logic [1:0]       lane_base, lane_new;
  len_t             rem_base, rem_new;

  m2bsh_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .prod (mul_p)
  );

  assign in_stall       = (state_r != S_IDLE);
  assign cfg_ready      = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;

  // Length masked to LENGTH_BITS
  assign len_ext = {16'b0, in_message_length};
  assign len_m   = len_ext[LENGTH_BITS-1:0];

  // Byte merge into the word being assembled
  always_comb begin
    w_base    = in_start_of_message ? '0 : w_r;
    lane_base = in_start_of_message ? 2'd0 : lane_r;
    rem_base  = in_start_of_message ? len_m : rem_r;
    w_new     = w_base | (32'(in_data_byte) << {lane_base, 3'b000});
    lane_new  = lane_base + 2'd1;
    rem_new   = rem_base - len_t'(1);
    k_mix     = mul_p ^ (mul_p >> m2bsh_pkg::WORD_SHIFT);
  end

  // Multiplier operand select
  always_comb begin
    case (state_r)
      S_K1:    mul_a = k_r;
      S_K2:    mul_a = k_mix;
      S_H1:    mul_a = h_r;
      S_T1:    mul_a = h_r ^ w_r;
      S_F1:    mul_a = h_r ^ (h_r >> m2bsh_pkg::END_SHIFT_A);
      default: mul_a = '0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = seed_r;
    h_nxt         = h_r;
    w_nxt         = w_r;
    k_nxt         = k_r;
    lane_nxt      = lane_r;
    rem_nxt       = rem_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && !out_acc;
    out_hash_nxt  = out_hash_r;

    if (cfg_valid && cfg_ready) begin
      seed_nxt = cfg_hash_seed;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_start_of_message && (len_m == '0)) begin
            // empty message: result 0 at once
            h_nxt     = '0;
            w_nxt     = '0;
            lane_nxt  = 2'd0;
            rem_nxt   = '0;
            state_nxt = S_EMIT;
          end else if (in_start_of_message || (rem_r != '0)) begin
            if (in_start_of_message) begin
              h_nxt = seed_r ^ 32'(len_m);
            end
            lane_nxt = lane_new;
            rem_nxt  = rem_new;
            if (lane_new == 2'd0) begin
              k_nxt     = w_new;
              w_nxt     = '0;
              fin_nxt   = (rem_new == '0);
              state_nxt = S_K1;
            end else if (rem_new == '0) begin
              w_nxt     = w_new;
              state_nxt = S_T1;
            end else begin
              w_nxt = w_new;
            end
          end
        end
      end
      S_K1: state_nxt = S_K2;
      S_K2: state_nxt = S_H1;
      S_H1: begin
        k_nxt     = mul_p;
        state_nxt = S_H2;
      end
      S_H2: begin
        h_nxt     = mul_p ^ k_r;
        state_nxt = fin_r ? S_F1 : S_IDLE;
      end
      S_T1: begin
        w_nxt     = '0;
        lane_nxt  = 2'd0;
        state_nxt = S_T2;
      end
      S_T2: begin
        h_nxt     = mul_p;
        state_nxt = S_F1;
      end
      S_F1: state_nxt = S_F2;
      S_F2: begin
        h_nxt     = mul_p ^ (mul_p >> m2bsh_pkg::END_SHIFT_B);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_acc) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = h_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seed_r      <= m2bsh_pkg::SEED_RESET;
      h_r         <= '0;
      w_r         <= '0;
      lane_r      <= 2'd0;
      rem_r       <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      h_r         <= h_nxt;
      w_r         <= w_nxt;
      lane_r      <= lane_nxt;
      rem_r       <= rem_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule

@@ design/m2bsh_mul.sv @@
// Shared multiply-by-M unit: low 32 bits of operand * 0x5bd1e995, registered.
// Depends on m2bsh_pkg.
`timescale 1ns / 1ps

module m2bsh_mul (
  input  logic               clk,
  input  m2bsh_pkg::word_t   op_a,
  output m2bsh_pkg::word_t   prod
);

  m2bsh_pkg::word_t prod_r;
  m2bsh_pkg::word_t prod_nxt;

  // Modulo-2^32 product, one result per cycle
  always_comb begin
    prod_nxt = op_a * m2bsh_pkg::MIX_MUL;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

@@ design/m2bsh_checker.sv @@
// Port-level checker for the MurmurHash2 byte-stream core, bound to the core module.
// Depends on murmur2_byte_stream_hash_core_macros.svh.
`timescale 1ns / 1ps
`include "murmur2_byte_stream_hash_core_macros.svh"

module m2bsh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_data_byte,
  input logic        in_start_of_message,
  input logic [15:0] in_message_length,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_hash_value,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [31:0] cfg_hash_seed
);

  logic in_acc;
  logic empty_msg;

  assign in_acc    = in_valid && !in_stall;
  assign empty_msg = in_start_of_message && (in_message_length == 16'd0);

  // A stalled result transaction holds
  `M2_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_hash_value), "stalled result changed")

  // An empty message keeps the core busy while its zero result is handed off
  `M2_ASSERT_NEXT(a_empty_busy, in_acc && empty_msg, in_stall, "empty message not processed")

  // A new result only appears after the core was busy
  `M2_ASSERT_NOW(a_result_src, $rose(out_valid), $past(in_stall), "result without busy phase")

  // Seed writes are only taken while input is open
  `M2_ASSERT_NOW(a_cfg_idle, cfg_valid && cfg_ready, !in_stall, "seed write while busy")

endmodule

bind murmur2_byte_stream_hash_core m2bsh_checker u_m2bsh_checker (.*);
